FILE: rtl/greek_to_latin_transliterator_defines.svh
// assertion macros for the greek to latin transliterator
// used by the top level only; no other dependencies
`ifndef GREEK_TO_LATIN_TRANSLITERATOR_DEFINES_SVH
`define GREEK_TO_LATIN_TRANSLITERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define GTL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gtl assertion failed");
`define GTL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gtl assertion failed");
`else
`define GTL_ASSERT_IMP(lbl, ante, cons)
`define GTL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/gtl_pkg.sv
// shared types, constants and the character mapping table
// no dependencies
package gtl_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] GR_MU_UP  = 8'd204;
    localparam logic [7:0] GR_MU_LO  = 8'd236;
    localparam logic [7:0] GR_NU_UP  = 8'd205;
    localparam logic [7:0] GR_NU_LO  = 8'd237;
    localparam logic [7:0] GR_PI_UP  = 8'd208;
    localparam logic [7:0] GR_PI_LO  = 8'd240;
    localparam logic [7:0] GR_TAU_UP = 8'd212;
    localparam logic [7:0] GR_TAU_LO = 8'd244;

    localparam logic [7:0] LAT_M_UP = 8'd77;
    localparam logic [7:0] LAT_M_LO = 8'd109;
    localparam logic [7:0] LAT_N_UP = 8'd78;
    localparam logic [7:0] LAT_N_LO = 8'd110;
    localparam logic [7:0] LAT_B_UP = 8'd66;
    localparam logic [7:0] LAT_B_LO = 8'd98;
    localparam logic [7:0] LAT_D_UP = 8'd68;
    localparam logic [7:0] LAT_D_LO = 8'd100;

    localparam logic [7:0] C_DQ = 8'd34;
    localparam logic [7:0] C_AP = 8'd39;

    // one queued work entry: up to four bytes, index of the final one
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // mapped sequence of one to three bytes
    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      len;
    } t_map;

    function automatic t_map mk1(input logic [7:0] a);
        t_map m;
        m.b   = {8'd0, 8'd0, a};
        m.len = 2'd1;
        return m;
    endfunction

    function automatic t_map mk2(input logic [7:0] a, input logic [7:0] b);
        t_map m;
        m.b   = {8'd0, b, a};
        m.len = 2'd2;
        return m;
    endfunction

    function automatic t_map mk3(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
        t_map m;
        m.b   = {c, b, a};
        m.len = 2'd3;
        return m;
    endfunction

    // unmapped bytes pass through as themselves
    function automatic t_map gtl_map(input logic [7:0] c);
        t_map m;
        unique case (c)
            8'd168: m = mk1(C_DQ);
            8'd180: m = mk1(C_AP);
            8'd181: m = mk2(C_AP, C_DQ);
            8'd182: m = mk2(C_AP, 8'd65);
            8'd184: m = mk2(C_AP, 8'd69);
            8'd185: m = mk2(C_AP, 8'd72);
            8'd186: m = mk2(C_AP, 8'd73);
            8'd188: m = mk2(C_AP, 8'd79);
            8'd190: m = mk2(C_AP, 8'd89);
            8'd191: m = mk2(C_AP, 8'd87);
            8'd192: m = mk3(8'd105, C_DQ, C_AP);
            8'd193: m = mk1(8'd65);
            8'd194: m = mk1(8'd86);
            8'd195: m = mk1(8'd71);
            8'd196: m = mk1(8'd68);
            8'd197: m = mk1(8'd69);
            8'd198: m = mk1(8'd90);
            8'd199: m = mk1(8'd72);
            8'd200: m = mk1(8'd56);
            8'd201: m = mk1(8'd73);
            8'd202: m = mk1(8'd75);
            8'd203: m = mk1(8'd76);
            8'd204: m = mk1(8'd77);
            8'd205: m = mk1(8'd78);
            8'd206: m = mk2(8'd75, 8'd83);
            8'd207: m = mk1(8'd79);
            8'd208: m = mk1(8'd80);
            8'd209: m = mk1(8'd82);
            8'd211: m = mk1(8'd83);
            8'd212: m = mk1(8'd84);
            8'd213: m = mk1(8'd89);
            8'd214: m = mk1(8'd70);
            8'd215: m = mk1(8'd88);
            8'd216: m = mk2(8'd80, 8'd83);
            8'd217: m = mk1(8'd87);
            8'd218: m = mk2(C_DQ, 8'd73);
            8'd219: m = mk2(C_DQ, 8'd89);
            8'd220: m = mk2(8'd97, C_AP);
            8'd221: m = mk2(8'd101, C_AP);
            8'd222: m = mk2(8'd104, C_AP);
            8'd223: m = mk2(8'd105, C_AP);
            8'd224: m = mk3(8'd121, C_DQ, C_AP);
            8'd225: m = mk1(8'd97);
            8'd226: m = mk1(8'd118);
            8'd227: m = mk1(8'd103);
            8'd228: m = mk1(8'd100);
            8'd229: m = mk1(8'd101);
            8'd230: m = mk1(8'd122);
            8'd231: m = mk1(8'd104);
            8'd232: m = mk1(8'd56);
            8'd233: m = mk1(8'd105);
            8'd234: m = mk1(8'd107);
            8'd235: m = mk1(8'd108);
            8'd236: m = mk1(8'd109);
            8'd237: m = mk1(8'd110);
            8'd238: m = mk2(8'd107, 8'd115);
            8'd239: m = mk1(8'd111);
            8'd240: m = mk1(8'd112);
            8'd241: m = mk1(8'd114);
            8'd242: m = mk1(8'd115);
            8'd243: m = mk1(8'd115);
            8'd244: m = mk1(8'd116);
            8'd245: m = mk1(8'd121);
            8'd246: m = mk1(8'd102);
            8'd247: m = mk1(8'd120);
            8'd248: m = mk2(8'd112, 8'd115);
            8'd249: m = mk1(8'd119);
            8'd250: m = mk2(8'd105, C_DQ);
            8'd251: m = mk2(8'd121, C_DQ);
            8'd252: m = mk2(8'd111, C_AP);
            8'd253: m = mk2(8'd121, C_AP);
            8'd254: m = mk2(8'd119, C_AP);
            default: m = mk1(c);
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/gtl_front.sv
// front end: accepts input bytes, tracks a held mu or nu, builds queue entries
// depends on gtl_pkg
module gtl_front import gtl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_q_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_flush,
    output logic       o_q_push,
    output t_entry     o_entry
);

    typedef enum logic [4:0] {
        P_NONE  = 5'b00001,
        P_MU_UP = 5'b00010,
        P_MU_LO = 5'b00100,
        P_NU_UP = 5'b01000,
        P_NU_LO = 5'b10000
    } t_pend;

    t_pend      r_pend;
    t_pend      n_pend;
    logic       w_accept;
    logic       w_has_held;
    logic       w_gen;
    logic       w_hold_letter;
    logic [7:0] w_held_byte;
    t_map       w_map;

    assign w_accept = i_push && !i_q_full;
    assign w_map    = gtl_map(i_in_byte);

    always_comb begin
        unique case (r_pend)
            P_MU_UP: w_held_byte = LAT_M_UP;
            P_MU_LO: w_held_byte = LAT_M_LO;
            P_NU_UP: w_held_byte = LAT_N_UP;
            P_NU_LO: w_held_byte = LAT_N_LO;
            default: w_held_byte = 8'd0;
        endcase
    end

    assign w_has_held    = (r_pend != P_NONE);
    assign w_hold_letter = (i_in_byte == GR_MU_UP) || (i_in_byte == GR_MU_LO) ||
                           (i_in_byte == GR_NU_UP) || (i_in_byte == GR_NU_LO);

    always_comb begin
        n_pend           = P_NONE;
        w_gen            = 1'b0;
        o_entry.bytes    = '0;
        o_entry.last_idx = 2'd0;
        if (i_flush) begin
            o_entry.bytes[0] = w_held_byte;
            w_gen            = w_has_held;
        end else if ((r_pend == P_MU_UP || r_pend == P_MU_LO) &&
                     (i_in_byte == GR_PI_UP || i_in_byte == GR_PI_LO)) begin
            // mu then pi folds to b
            o_entry.bytes[0] = (r_pend == P_MU_UP) ? LAT_B_UP : LAT_B_LO;
            w_gen            = 1'b1;
        end else if ((r_pend == P_NU_UP || r_pend == P_NU_LO) &&
                     (i_in_byte == GR_TAU_UP || i_in_byte == GR_TAU_LO)) begin
            // nu then tau folds to d
            o_entry.bytes[0] = (r_pend == P_NU_UP) ? LAT_D_UP : LAT_D_LO;
            w_gen            = 1'b1;
        end else begin
            priority if (i_in_byte == GR_MU_UP) n_pend = P_MU_UP;
            else if (i_in_byte == GR_MU_LO)     n_pend = P_MU_LO;
            else if (i_in_byte == GR_NU_UP)     n_pend = P_NU_UP;
            else if (i_in_byte == GR_NU_LO)     n_pend = P_NU_LO;
            else                                n_pend = P_NONE;
            if (w_has_held) begin
                o_entry.bytes    = {w_map.b[2], w_map.b[1], w_map.b[0], w_held_byte};
                o_entry.last_idx = w_hold_letter ? 2'd0 : w_map.len;
                w_gen            = 1'b1;
            end else begin
                o_entry.bytes    = {8'd0, w_map.b[2], w_map.b[1], w_map.b[0]};
                o_entry.last_idx = w_map.len - 2'd1;
                w_gen            = !w_hold_letter;
            end
        end
    end

    assign o_q_push = w_accept && w_gen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= P_NONE;
        end else if (w_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

FILE: rtl/gtl_queue.sv
// short entry queue between front and back ends
// depends on gtl_pkg
module gtl_queue import gtl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_deq,
    output t_entry  o_entry,
    output t_q_stat o_stat
);

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic [Q_CW-1:0]   n_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr         = i_push && !o_stat.full;
    assign w_rd         = i_deq && !o_stat.empty;
    assign o_entry      = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + Q_CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

FILE: rtl/gtl_back.sv
// back end: walks each queued entry byte by byte into the output register
// depends on gtl_pkg
module gtl_back import gtl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_entry,
    input  t_q_stat    i_stat,
    output logic       o_deq,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_last;
    logic       w_load;
    logic       w_is_last;

    // output register refills on the same edge its byte is taken
    assign w_load    = !i_stat.empty && (!r_valid || i_pop);
    assign w_is_last = (r_idx == i_entry.last_idx);
    assign o_deq     = w_load && w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_entry.bytes[r_idx];
            r_last <= w_is_last;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

FILE: rtl/greek_to_latin_transliterator.sv
// path: an input enters the queue, then its first byte the output register
// throughput: one input per cycle into a four-entry queue while full is low; results
// leave at one byte per cycle while pop is high; an input produces 0 to 4 bytes
// reset: synchronous active-low i_rst_n clears the held letter, queue and output
// register valid flag; full and empty are valid the cycle after reset is released
module greek_to_latin_transliterator import gtl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_flush,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

`include "greek_to_latin_transliterator_defines.svh"

    logic    w_q_push;
    t_entry  w_front_entry;
    t_entry  w_head_entry;
    t_q_stat w_qstat;
    logic    w_deq;

    assign full = w_qstat.full;

    gtl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_q_full  (w_qstat.full),
        .i_in_byte (i_in_byte),
        .i_flush   (i_flush),
        .o_q_push  (w_q_push),
        .o_entry   (w_front_entry)
    );

    gtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_front_entry),
        .i_deq   (w_deq),
        .o_entry (w_head_entry),
        .o_stat  (w_qstat)
    );

    gtl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_head_entry),
        .i_stat     (w_qstat),
        .o_deq      (w_deq),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    `GTL_ASSERT_IMP(a_no_overflow, w_q_push, !w_qstat.full)
    `GTL_ASSERT_IMP(a_out_from_queue, $fell(empty), $past(!w_qstat.empty))
    `GTL_ASSERT_NXT(a_deq_on_last, w_deq, !empty && o_last)

endmodule

FILE: test/tb_greek_to_latin_transliterator.sv
// testbench for greek_to_latin_transliterator: directed table then random text
// bytes, each output transfer checked against a typed row's bytes or a local
// transliteration predictor; depends on gtl_pkg for greek and latin codes
`timescale 1ns / 100ps

module tb_greek_to_latin_transliterator;
    import gtl_pkg::*;

    typedef enum logic [2:0] {
        HOLD_NONE,
        HOLD_MU_UP,
        HOLD_MU_LO,
        HOLD_NU_UP,
        HOLD_NU_LO
    } t_hold;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } t_outbyte;

    // typed rows carry their own expected bytes, first byte in seq[7:0]
    typedef struct packed {
        logic [7:0]  ch;
        logic        fl;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] seq;
    } t_step_row;

    localparam int N_DIR      = 26;
    localparam int N_RAND     = 204;
    localparam int CALM_ITEMS = 30;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'd0;
    logic       i_flush = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last;

    t_hold    held = HOLD_NONE;
    t_outbyte latin_queue[$];
    t_outbyte want;
    int       fail_count = 0;
    int       n_sent = 0;
    int       n_flush = 0;
    int       n_checked = 0;
    bit       calm = 1'b0;
    bit       paused = 1'b0;

    t_step_row dir_rows [N_DIR] = '{
        '{8'd0,      1'b0, 1'b1, 3'd1, {24'd0, 8'd0}},
        '{8'd255,    1'b0, 1'b1, 3'd1, {24'd0, 8'd255}},
        '{8'd0,      1'b1, 1'b1, 3'd0, 32'd0},
        '{8'd218,    1'b0, 1'b1, 3'd2, {16'd0, 8'd73, C_DQ}},
        '{8'd219,    1'b0, 1'b1, 3'd2, {16'd0, 8'd89, C_DQ}},
        '{8'd192,    1'b0, 1'b1, 3'd3, {8'd0, C_AP, C_DQ, 8'd105}},
        '{8'd127,    1'b0, 1'b1, 3'd1, {24'd0, 8'd127}},
        '{8'd210,    1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_MU_UP,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_PI_UP,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_MU_LO,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_PI_UP,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_NU_UP,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_TAU_LO, 1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_NU_LO,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_TAU_UP, 1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_MU_UP,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_NU_LO,  1'b0, 1'b0, 3'd0, 32'd0},
        '{8'd224,    1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_NU_UP,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_PI_LO,  1'b0, 1'b0, 3'd0, 32'd0},
        '{GR_MU_LO,  1'b0, 1'b0, 3'd0, 32'd0},
        '{8'd255,    1'b1, 1'b0, 3'd0, 32'd0},
        '{GR_NU_LO,  1'b0, 1'b0, 3'd0, 32'd0},
        '{8'd128,    1'b0, 1'b0, 3'd0, 32'd0},
        '{8'd254,    1'b0, 1'b0, 3'd0, 32'd0}
    };

    greek_to_latin_transliterator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .i_flush    (i_flush),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    always #5 i_clk = ~i_clk;

    // {length, first, second, third}; unmapped bytes pass through with length 1
    function automatic logic [25:0] latin_seq(input logic [7:0] c);
        logic [25:0] s;
        case (c)
            8'd168: s = {2'd1, C_DQ, 16'd0};
            8'd180: s = {2'd1, C_AP, 16'd0};
            8'd181: s = {2'd2, C_AP, C_DQ, 8'd0};
            8'd182: s = {2'd2, C_AP, 8'd65, 8'd0};
            8'd184: s = {2'd2, C_AP, 8'd69, 8'd0};
            8'd185: s = {2'd2, C_AP, 8'd72, 8'd0};
            8'd186: s = {2'd2, C_AP, 8'd73, 8'd0};
            8'd188: s = {2'd2, C_AP, 8'd79, 8'd0};
            8'd190: s = {2'd2, C_AP, 8'd89, 8'd0};
            8'd191: s = {2'd2, C_AP, 8'd87, 8'd0};
            8'd192: s = {2'd3, 8'd105, C_DQ, C_AP};
            8'd193: s = {2'd1, 8'd65, 16'd0};
            8'd194: s = {2'd1, 8'd86, 16'd0};
            8'd195: s = {2'd1, 8'd71, 16'd0};
            8'd196: s = {2'd1, 8'd68, 16'd0};
            8'd197: s = {2'd1, 8'd69, 16'd0};
            8'd198: s = {2'd1, 8'd90, 16'd0};
            8'd199: s = {2'd1, 8'd72, 16'd0};
            8'd200: s = {2'd1, 8'd56, 16'd0};
            8'd201: s = {2'd1, 8'd73, 16'd0};
            8'd202: s = {2'd1, 8'd75, 16'd0};
            8'd203: s = {2'd1, 8'd76, 16'd0};
            8'd206: s = {2'd2, 8'd75, 8'd83, 8'd0};
            8'd207: s = {2'd1, 8'd79, 16'd0};
            8'd208: s = {2'd1, 8'd80, 16'd0};
            8'd209: s = {2'd1, 8'd82, 16'd0};
            8'd211: s = {2'd1, 8'd83, 16'd0};
            8'd212: s = {2'd1, 8'd84, 16'd0};
            8'd213: s = {2'd1, 8'd89, 16'd0};
            8'd214: s = {2'd1, 8'd70, 16'd0};
            8'd215: s = {2'd1, 8'd88, 16'd0};
            8'd216: s = {2'd2, 8'd80, 8'd83, 8'd0};
            8'd217: s = {2'd1, 8'd87, 16'd0};
            8'd218: s = {2'd2, C_DQ, 8'd73, 8'd0};
            8'd219: s = {2'd2, C_DQ, 8'd89, 8'd0};
            8'd220: s = {2'd2, 8'd97, C_AP, 8'd0};
            8'd221: s = {2'd2, 8'd101, C_AP, 8'd0};
            8'd222: s = {2'd2, 8'd104, C_AP, 8'd0};
            8'd223: s = {2'd2, 8'd105, C_AP, 8'd0};
            8'd224: s = {2'd3, 8'd121, C_DQ, C_AP};
            8'd225: s = {2'd1, 8'd97, 16'd0};
            8'd226: s = {2'd1, 8'd118, 16'd0};
            8'd227: s = {2'd1, 8'd103, 16'd0};
            8'd228: s = {2'd1, 8'd100, 16'd0};
            8'd229: s = {2'd1, 8'd101, 16'd0};
            8'd230: s = {2'd1, 8'd122, 16'd0};
            8'd231: s = {2'd1, 8'd104, 16'd0};
            8'd232: s = {2'd1, 8'd56, 16'd0};
            8'd233: s = {2'd1, 8'd105, 16'd0};
            8'd234: s = {2'd1, 8'd107, 16'd0};
            8'd235: s = {2'd1, 8'd108, 16'd0};
            8'd238: s = {2'd2, 8'd107, 8'd115, 8'd0};
            8'd239: s = {2'd1, 8'd111, 16'd0};
            8'd240: s = {2'd1, 8'd112, 16'd0};
            8'd241: s = {2'd1, 8'd114, 16'd0};
            8'd242: s = {2'd1, 8'd115, 16'd0};
            8'd243: s = {2'd1, 8'd115, 16'd0};
            8'd244: s = {2'd1, 8'd116, 16'd0};
            8'd245: s = {2'd1, 8'd121, 16'd0};
            8'd246: s = {2'd1, 8'd102, 16'd0};
            8'd247: s = {2'd1, 8'd120, 16'd0};
            8'd248: s = {2'd2, 8'd112, 8'd115, 8'd0};
            8'd249: s = {2'd1, 8'd119, 16'd0};
            8'd250: s = {2'd2, 8'd105, C_DQ, 8'd0};
            8'd251: s = {2'd2, 8'd121, C_DQ, 8'd0};
            8'd252: s = {2'd2, 8'd111, C_AP, 8'd0};
            8'd253: s = {2'd2, 8'd121, C_AP, 8'd0};
            8'd254: s = {2'd2, 8'd119, C_AP, 8'd0};
            default: s = {2'd1, c, 16'd0};
        endcase
        return s;
    endfunction

    function automatic logic [7:0] held_latin(input t_hold h);
        case (h)
            HOLD_MU_UP: return LAT_M_UP;
            HOLD_MU_LO: return LAT_M_LO;
            HOLD_NU_UP: return LAT_N_UP;
            default:    return LAT_N_LO;
        endcase
    endfunction

    // advances the held letter and returns the bytes one input produces
    function automatic void transliterate(input logic [7:0] c, input logic fl,
                                          output int n, output logic [3:0][7:0] seq);
        logic [25:0] m;
        t_hold       nxt;
        bit          merged;
        int          k;
        n      = 0;
        seq    = '0;
        nxt    = HOLD_NONE;
        merged = 1'b0;
        if (fl) begin
            if (held != HOLD_NONE) begin
                seq[n] = held_latin(held);
                n++;
            end
        end else begin
            if ((held == HOLD_MU_UP || held == HOLD_MU_LO) &&
                (c == GR_PI_UP || c == GR_PI_LO)) begin
                seq[0] = (held == HOLD_MU_UP) ? LAT_B_UP : LAT_B_LO;
                n      = 1;
                merged = 1'b1;
            end else if ((held == HOLD_NU_UP || held == HOLD_NU_LO) &&
                         (c == GR_TAU_UP || c == GR_TAU_LO)) begin
                seq[0] = (held == HOLD_NU_UP) ? LAT_D_UP : LAT_D_LO;
                n      = 1;
                merged = 1'b1;
            end
            if (!merged) begin
                if (held != HOLD_NONE) begin
                    seq[n] = held_latin(held);
                    n++;
                end
                case (c)
                    GR_MU_UP: nxt = HOLD_MU_UP;
                    GR_MU_LO: nxt = HOLD_MU_LO;
                    GR_NU_UP: nxt = HOLD_NU_UP;
                    GR_NU_LO: nxt = HOLD_NU_LO;
                    default: begin
                        m = latin_seq(c);
                        for (k = 0; k < int'(m[25:24]); k++) begin
                            seq[n] = m[23 - 8 * k -: 8];
                            n++;
                        end
                    end
                endcase
            end
        end
        held = nxt;
    endfunction

    function automatic void queue_bytes(input int n, input logic [3:0][7:0] seq);
        int k;
        for (k = 0; k < n; k++)
            latin_queue.push_back('{seq[k], k == n - 1});
    endfunction

    function automatic logic [7:0] rand_mu_nu();
        case ($urandom_range(0, 3))
            0: return GR_MU_UP;
            1: return GR_MU_LO;
            2: return GR_NU_UP;
            default: return GR_NU_LO;
        endcase
    endfunction

    function automatic logic [7:0] rand_pi_tau();
        case ($urandom_range(0, 3))
            0: return GR_PI_UP;
            1: return GR_PI_LO;
            2: return GR_TAU_UP;
            default: return GR_TAU_LO;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send(input logic [7:0] ch, input logic fl, input logic typed,
                        input logic [2:0] tn, input logic [31:0] tseq);
        int              pn;
        logic [3:0][7:0] ps;
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= ch;
        i_flush   <= fl;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        transliterate(ch, fl, pn, ps);
        if (typed)
            queue_bytes(int'(tn), tseq);
        else
            queue_bytes(pn, ps);
        n_sent++;
        if (fl)
            n_flush++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0) begin
            if (latin_queue.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected output byte %0d last %0b at %0t",
                             o_out_byte, o_last, $time);
                fail_count++;
            end else begin
                want = latin_queue.pop_front();
                n_checked++;
                if (o_out_byte !== want.ch || o_last !== want.is_last) begin
                    if (fail_count < 10)
                        $display({"mismatch at %0t: expected byte %0d last %0b, ",
                                  "got byte %0d last %0b"},
                                 $time, want.ch, want.is_last, o_out_byte, o_last);
                    fail_count++;
                end
            end
        end
    end

    // receiver: pop stays high apart from short random stall bursts
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int         r;
        int         rand_target;
        logic [7:0] c;
        rand_target = N_DIR + N_RAND;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send(dir_rows[i].ch, dir_rows[i].fl, dir_rows[i].typed,
                 dir_rows[i].n, dir_rows[i].seq);

        while (n_sent < rand_target) begin
            calm = (n_sent >= rand_target - CALM_ITEMS);
            // hold the input back once until the output side has drained
            if (!paused && n_sent >= N_DIR + 110) begin
                paused = 1'b1;
                push <= 1'b0;
                @(negedge i_clk);
                while (latin_queue.size() != 0) @(negedge i_clk);
            end
            r = $urandom_range(0, 9);
            if (r <= 2) begin
                send(rand_mu_nu(), 1'b0, 1'b0, 3'd0, 32'd0);
                send(rand_pi_tau(), 1'b0, 1'b0, 3'd0, 32'd0);
            end else if (r <= 5) begin
                send(8'($urandom_range(180, 254)), 1'b0, 1'b0, 3'd0, 32'd0);
            end else if (r == 6) begin
                send(rand_mu_nu(), 1'b0, 1'b0, 3'd0, 32'd0);
                c = $urandom_range(0, 1) ? rand_mu_nu() : 8'($urandom_range(0, 255));
                send(c, 1'b0, 1'b0, 3'd0, 32'd0);
            end else if (r == 7) begin
                send(8'($urandom_range(0, 255)), 1'b1, 1'b0, 3'd0, 32'd0);
            end else begin
                send(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                     1'b0, 3'd0, 32'd0);
            end
        end
        push <= 1'b0;

        while (latin_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d input transfers (%0d flushes), directed table then random text",
                 n_sent, n_flush);
        $display("checked %0d output bytes, %0d failures", n_checked, fail_count);
        if (fail_count == 0 && latin_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/gtl_pkg.sv
rtl/gtl_front.sv
rtl/gtl_queue.sv
rtl/gtl_back.sv
rtl/greek_to_latin_transliterator.sv
test/tb_greek_to_latin_transliterator.sv
